>>> design/array_key_value_map_core_assert.svh
// assertion macros for the key-value map core
// used by array_key_value_map_core; expects i_clk and i_rst_n in scope
`ifndef ARRAY_KEY_VALUE_MAP_CORE_ASSERT_SVH
`define ARRAY_KEY_VALUE_MAP_CORE_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define AKVM_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define AKVM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AKVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/akvm_pkg.sv
// shared types and codes for the key-value map core
// no dependencies
`default_nettype none

package akvm_pkg;

    localparam int unsigned FIELD_BITS = 32;
    localparam int unsigned COUNT_OUT_BITS = 7;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_ABSENT = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] value;
    } t_req;

    typedef struct packed {
        logic [FIELD_BITS-1:0]     read_value;
        logic                      hit;
        logic [1:0]                status;
        logic [COUNT_OUT_BITS-1:0] entry_count;
    } t_rsp;

endpackage

`default_nettype wire

>>> design/akvm_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module akvm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/array_key_value_map_core.sv
// lookup, write and delete scan the entries from index 0 and stop at the first key match;
// a miss scans all used entries; delete compacts only the entries after the match
// one request at a time: the key/value memories' single read port walks one entry a cycle
// a finished result sits in an output register, so the next request is taken meanwhile
// reset empties the table at once (entry count to zero); stored entries need no clearing
// depends on akvm_pkg, akvm_ram and array_key_value_map_core_assert.svh
`default_nettype none

`include "array_key_value_map_core_assert.svh"

module array_key_value_map_core #(
    parameter int unsigned CAPACITY   = 64,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire akvm_pkg::t_req i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output akvm_pkg::t_rsp    o_out_data
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_MISS  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // control
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_issue, n_issue;
    logic          r_chk_valid, n_chk_valid;
    logic          r_out_valid, n_out_valid;
    // payload
    logic [1:0]            r_req_type, n_req_type;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [AW-1:0]         r_rd_idx, n_rd_idx;
    logic [AW-1:0]         r_chk_idx, n_chk_idx;
    logic [akvm_pkg::FIELD_BITS-1:0] r_res_value, n_res_value;
    logic          r_res_hit, n_res_hit;
    logic [1:0]    r_res_status, n_res_status;
    akvm_pkg::t_rsp r_out, n_out;

    // memory ports
    logic                  key_we, val_we;
    logic [AW-1:0]         mem_waddr;
    logic [KEY_BITS-1:0]   key_wdata, key_rdata;
    logic [VALUE_BITS-1:0] val_wdata, val_rdata;

    logic [63:0]   key_in_ext, val_in_ext, val_rd_ext;
    logic [31:0]   count_ext;
    logic [CW-1:0] cnt_m1;
    logic          rd_last, chk_last, accept;
    logic          chk_active, clear_accept, out_hit;

    akvm_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (mem_waddr),
        .i_wdata (key_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (key_rdata)
    );

    akvm_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (mem_waddr),
        .i_wdata (val_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (val_rdata)
    );

    assign key_in_ext = 64'(i_in_data.key);
    assign val_in_ext = 64'(i_in_data.value);
    assign val_rd_ext = 64'(val_rdata);
    assign count_ext  = 32'(r_count);
    assign cnt_m1     = r_count - CW'(1);
    assign rd_last    = CW'(r_rd_idx) == cnt_m1;
    assign chk_last   = CW'(r_chk_idx) == cnt_m1;
    assign accept     = i_in_valid && (r_state == S_IDLE);

    assign chk_active   = r_chk_valid && (r_state == S_SCAN || r_state == S_SHIFT);
    assign clear_accept = accept && (i_in_data.req_type == akvm_pkg::REQ_CLEAR);
    assign out_hit      = o_out_valid && o_out_data.hit;

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_issue      = r_issue;
        n_chk_valid  = r_chk_valid;
        n_out_valid  = r_out_valid;
        n_req_type   = r_req_type;
        n_key        = r_key;
        n_val        = r_val;
        n_rd_idx     = r_rd_idx;
        n_chk_idx    = r_chk_idx;
        n_res_value  = r_res_value;
        n_res_hit    = r_res_hit;
        n_res_status = r_res_status;
        n_out        = r_out;
        key_we       = 1'b0;
        val_we       = 1'b0;
        mem_waddr    = r_chk_idx;
        key_wdata    = key_rdata;
        val_wdata    = val_rdata;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req_type   = i_in_data.req_type;
                    n_key        = key_in_ext[KEY_BITS-1:0];
                    n_val        = val_in_ext[VALUE_BITS-1:0];
                    n_res_value  = '0;
                    n_res_hit    = 1'b0;
                    n_res_status = akvm_pkg::STATUS_OK;
                    n_rd_idx     = '0;
                    n_issue      = 1'b1;
                    n_chk_valid  = 1'b0;
                    priority if (i_in_data.req_type == akvm_pkg::REQ_CLEAR) begin
                        n_count = '0;
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_state = S_MISS;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // one read issued a cycle, compared when the data comes back
                if (r_issue) begin
                    n_rd_idx = r_rd_idx + AW'(1);
                    if (rd_last) begin
                        n_issue = 1'b0;
                    end
                end
                n_chk_valid = r_issue;
                n_chk_idx   = r_rd_idx;
                if (r_chk_valid) begin
                    if (key_rdata == r_key) begin
                        n_res_hit = 1'b1;
                        n_state   = S_DONE;
                        unique case (r_req_type)
                            akvm_pkg::REQ_LOOKUP: begin
                                n_res_value = val_rd_ext[akvm_pkg::FIELD_BITS-1:0];
                            end
                            akvm_pkg::REQ_WRITE: begin
                                val_we    = 1'b1;
                                val_wdata = r_val;
                            end
                            akvm_pkg::REQ_DELETE: begin
                                if (chk_last) begin
                                    n_count = cnt_m1;
                                end else begin
                                    // compact: walk later entries down one place
                                    n_rd_idx    = r_chk_idx + AW'(1);
                                    n_issue     = 1'b1;
                                    n_chk_valid = 1'b0;
                                    n_state     = S_SHIFT;
                                end
                            end
                            akvm_pkg::REQ_CLEAR: begin
                                n_count = '0;
                            end
                        endcase
                    end else if (chk_last) begin
                        n_state = S_MISS;
                    end
                end
            end
            S_SHIFT: begin
                // reads run two entries ahead of the write-back address, never the same address
                if (r_issue) begin
                    n_rd_idx = r_rd_idx + AW'(1);
                    if (rd_last) begin
                        n_issue = 1'b0;
                    end
                end
                n_chk_valid = r_issue;
                n_chk_idx   = r_rd_idx;
                if (r_chk_valid) begin
                    key_we    = 1'b1;
                    val_we    = 1'b1;
                    mem_waddr = r_chk_idx - AW'(1);
                    if (chk_last) begin
                        n_count = cnt_m1;
                        n_state = S_DONE;
                    end
                end
            end
            S_MISS: begin
                n_state = S_DONE;
                unique case (r_req_type)
                    akvm_pkg::REQ_LOOKUP: begin
                        n_res_value = '0;
                    end
                    akvm_pkg::REQ_WRITE: begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_res_status = akvm_pkg::STATUS_FULL;
                        end else begin
                            key_we    = 1'b1;
                            val_we    = 1'b1;
                            mem_waddr = r_count[AW-1:0];
                            key_wdata = r_key;
                            val_wdata = r_val;
                            n_count   = r_count + CW'(1);
                        end
                    end
                    akvm_pkg::REQ_DELETE: begin
                        n_res_status = akvm_pkg::STATUS_ABSENT;
                    end
                    akvm_pkg::REQ_CLEAR: begin
                        n_count = '0;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.read_value  = r_res_value;
                    n_out.hit         = r_res_hit;
                    n_out.status      = r_res_status;
                    n_out.entry_count = count_ext[akvm_pkg::COUNT_OUT_BITS-1:0];
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue     <= 1'b0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type   <= n_req_type;
        r_key        <= n_key;
        r_val        <= n_val;
        r_rd_idx     <= n_rd_idx;
        r_chk_idx    <= n_chk_idx;
        r_res_value  <= n_res_value;
        r_res_hit    <= n_res_hit;
        r_res_status <= n_res_status;
        r_out        <= n_out;
    end

    `AKVM_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(CAPACITY), "entry count above capacity")
    `AKVM_ASSERT_SAME(a_chk_in_range, chk_active, CW'(r_chk_idx) < r_count, "compare past used")
    `AKVM_ASSERT_NEXT(a_clear_empties, clear_accept, r_count == '0, "clear left entries behind")
    `AKVM_ASSERT_SAME(a_hit_is_ok, out_hit, o_out_data.status == akvm_pkg::STATUS_OK, "hit error")

endmodule

`default_nettype wire
